>>> sv/firlp_pkg.sv
// ----------------------------------------------------------------------------
// firlp_pkg
// Shared types and constants of the 40-tap low-pass FIR: word widths,
// the symmetric Q1.15 coefficient ROM and the MAC control bundle.
// ----------------------------------------------------------------------------
package firlp_pkg;

	// fixed widths of the channel words
	localparam int SAMPLE_W = 12;
	localparam int RESULT_W = 12;

	// coefficient ROM: 40 taps, Q1.15, symmetric about the middle
	localparam int ROM_TAPS  = 40;
	localparam int ROM_HALF  = 20;
	localparam int ROM_W     = 16;
	localparam int ROM_IDX_W = 6;

	typedef logic [ROM_W-1:0] rom_word_t;

	localparam rom_word_t COEF_HALF [ROM_HALF] = '{
		16'd1,   16'd1,   16'd1,   16'd2,    16'd2,
		16'd4,   16'd5,   16'd8,   16'd11,   16'd15,
		16'd21,  16'd29,  16'd42,  16'd61,   16'd92,
		16'd146, 16'd252, 16'd512, 16'd1457, 16'd13261
	};

	// control that travels with a tap into the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic valid;
		logic last;
	} mac_ctl_t;

	// coefficient of tap k; taps past the ROM read as zero
	function automatic rom_word_t rom_coef(input logic [ROM_IDX_W-1:0] k);
		logic [ROM_IDX_W-1:0] m;
		rom_word_t c;
		m = '0;
		c = '0;
		if (k < ROM_IDX_W'(ROM_TAPS)) begin
			if (k < ROM_IDX_W'(ROM_HALF)) begin
				m = k;
			end else begin
				m = ROM_IDX_W'(ROM_TAPS - 1) - k;
			end
			c = COEF_HALF[m[4:0]];
		end
		return c;
	endfunction

endpackage

>>> sv/firlp_in_if.sv
// ----------------------------------------------------------------------------
// firlp_in_if
// Sample channel: one converter sample per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface firlp_in_if;
	logic                           valid;
	logic                           ready;
	logic [firlp_pkg::SAMPLE_W-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

>>> sv/firlp_out_if.sv
// ----------------------------------------------------------------------------
// firlp_out_if
// Result channel: one filtered value per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface firlp_out_if;
	logic                           valid;
	logic                           ready;
	logic [firlp_pkg::RESULT_W-1:0] filtered_value;

	modport source (output valid, output filtered_value, input ready);
	modport sink (input valid, input filtered_value, output ready);
endinterface

>>> sv/fir_lowpass_40tap_unit.sv
// ----------------------------------------------------------------------------
// fir_lowpass_40tap_unit
// Symmetric low-pass FIR over converter samples, one filtered word per sample.
// ----------------------------------------------------------------------------
// Each accepted sample word is written into a TAPS-entry sample memory with a
// registered read, and the filter output is built by one shared multiplier
// walking the taps newest first, one memory read per cycle, through the single
// memory read port. After the tap walk an item passes the MAC drain and a
// finish state; its result is loaded into the output register once that
// register is empty or its word is taken. A new sample is taken once the
// previous result sits in the output register. Memory entries never written
// since reset read as zero through per-entry valid flops, so no clearing pass
// is needed. The output is the accumulated sum rounded half up and clamped to
// the sample range.
// ----------------------------------------------------------------------------
module fir_lowpass_40tap_unit #(
	parameter int TAPS        = 40,
	parameter int SAMPLE_BITS = 12,
	parameter int COEF_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	firlp_in_if.sink           samples,
	firlp_out_if.source        results
);

	localparam int AW    = $clog2(TAPS);
	localparam int ACC_W = SAMPLE_BITS + COEF_BITS + $clog2(TAPS) + 1;
	localparam int SH_L  = (COEF_BITS >= firlp_pkg::ROM_W) ? COEF_BITS - firlp_pkg::ROM_W : 0;
	localparam int SH_R  = (COEF_BITS < firlp_pkg::ROM_W) ? firlp_pkg::ROM_W - COEF_BITS : 0;
	localparam int EXT_W = COEF_BITS + firlp_pkg::ROM_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]             state_q;
	logic [AW-1:0]          pos_q;
	logic [AW-1:0]          rd_addr_q;
	logic [AW-1:0]          k_q;
	logic [TAPS-1:0]        valid_q;
	logic [SAMPLE_BITS-1:0] mem [TAPS];

	logic [SAMPLE_BITS-1:0] rdata_s1;
	logic                   ok_s1;
	logic [COEF_BITS-1:0]   coef_s1;
	logic                   v_s1;
	logic                   last_s1;

	logic                           out_valid_q;
	logic [firlp_pkg::RESULT_W-1:0] out_q;

	logic                 accept;
	logic                 load_out;
	logic [EXT_W-1:0]     coef_ext;
	logic [COEF_BITS-1:0] coef_k;
	logic [ACC_W-1:0]     acc;
	logic                 mac_done;
	logic [ACC_W:0]       rounded;
	logic [ACC_W:0]       clamped;
	firlp_pkg::mac_ctl_t  mac_ctl;

	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && (state_q == ST_IDLE);
	assign load_out      = (state_q == ST_FINISH) && (!out_valid_q || results.ready);

	// coefficient of the tap being issued, rescaled to COEF_BITS
	always_comb begin
		coef_ext = EXT_W'(firlp_pkg::rom_coef(firlp_pkg::ROM_IDX_W'(k_q)));
		if (COEF_BITS >= firlp_pkg::ROM_W) begin
			coef_k = COEF_BITS'(coef_ext << SH_L);
		end else begin
			coef_k = COEF_BITS'(coef_ext >> SH_R);
		end
	end

	// sample memory: write on accept, one tap read per cycle during the walk
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[pos_q] <= SAMPLE_BITS'(samples.adc_sample);
		end
		if (state_q == ST_RUN) begin
			rdata_s1 <= mem[rd_addr_q];
		end
		coef_s1 <= coef_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			rd_addr_q <= '0;
			k_q       <= '0;
			valid_q   <= '0;
			ok_s1     <= 1'b0;
			v_s1      <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			v_s1    <= (state_q == ST_RUN);
			last_s1 <= (state_q == ST_RUN) && (k_q == AW'(TAPS - 1));
			ok_s1   <= valid_q[rd_addr_q];
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						valid_q[pos_q] <= 1'b1;
						rd_addr_q      <= pos_q;
						k_q            <= '0;
						pos_q          <= (pos_q == AW'(TAPS - 1)) ? '0 : pos_q + 1'b1;
						state_q        <= ST_RUN;
					end
				end
				ST_RUN: begin
					// walk back from the newest sample, wrapping at the bottom
					rd_addr_q <= (rd_addr_q == '0) ? AW'(TAPS - 1) : rd_addr_q - 1'b1;
					if (k_q == AW'(TAPS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign mac_ctl.clear = accept;
	assign mac_ctl.valid = v_s1;
	assign mac_ctl.last  = last_s1;

	firlp_mac #(
		.SB    (SAMPLE_BITS),
		.CB    (COEF_BITS),
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.sample (ok_s1 ? rdata_s1 : '0),
		.coef   (coef_s1),
		.acc    (acc),
		.done   (mac_done)
	);

	// round half up, drop the fraction, clamp to the sample range
	always_comb begin
		rounded = ((ACC_W+1)'(acc) + ((ACC_W+1)'(1) << (COEF_BITS - 2))) >> (COEF_BITS - 1);
		if (rounded > (ACC_W+1)'((64'd1 << SAMPLE_BITS) - 64'd1)) begin
			clamped = (ACC_W+1)'((64'd1 << SAMPLE_BITS) - 64'd1);
		end else begin
			clamped = rounded;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= firlp_pkg::RESULT_W'(clamped);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.filtered_value = out_q;

`ifndef NO_ASSERTIONS
	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> state_q == ST_RUN)
		else $error("accepted word did not start the tap walk");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= AW'(TAPS - 1))
		else $error("write position past the last tap");

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_DRAIN)
		else $error("mac finished outside the drain phase");

	a_load_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("output loaded without a finished sum");

	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && k_q == AW'(TAPS - 1) |=> state_q == ST_DRAIN)
		else $error("tap walk did not end after the last tap");
`endif

endmodule

>>> sv/firlp_mac.sv
// ----------------------------------------------------------------------------
// firlp_mac
// Shared multiply-accumulate unit: registered product, then accumulate.
// Raises done in the same cycle that the accumulator first holds the last tap.
// ----------------------------------------------------------------------------
module firlp_mac #(
	parameter int SB    = 12,
	parameter int CB    = 16,
	parameter int ACC_W = 35
) (
	input  logic                clk,
	input  logic                arst_n,
	input  firlp_pkg::mac_ctl_t ctl,
	input  logic [SB-1:0]       sample,
	input  logic [CB-1:0]       coef,
	output logic [ACC_W-1:0]    acc,
	output logic                done
);

	logic [SB+CB-1:0] prod_s2;
	logic             v_s2;
	logic             last_s2;
	logic [ACC_W-1:0] acc_q;
	logic             done_q;

	always_ff @(posedge clk) begin
		prod_s2 <= (SB+CB)'(sample) * (SB+CB)'(coef);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			acc_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			v_s2    <= ctl.valid;
			last_s2 <= ctl.valid && ctl.last;
			done_q  <= v_s2 && last_s2;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule
